// ===== design/rrah_pkg.sv =====
`default_nettype none
package rrah_pkg;

   // normalized magnitudes sit in [2^(NORM_TOP-1), 2^NORM_TOP)
   localparam int NORM_TOP = 58;
   localparam int NORM_STEPS = 6;
   localparam int CORDIC_STEPS = 32;
   localparam int CX_W = 61;
   localparam int ACC_W = 43;
   localparam int REM_W = ACC_W;
   localparam int QUOT_W = 16;
   localparam int ANGLE_W = 15;
   localparam int ANGLE_LIMIT = 9000;

   // angle accumulator counts 1e-10 degree
   localparam logic signed [ACC_W-1:0] HALF_HUNDREDTH = 43'sd50000000;

   // one hundredth of a degree is 2^8 * 5^8 accumulator units; the 5^8 part
   // uses a rounded-up reciprocal, exact for any 32-bit dividend
   localparam int PRE_SHIFT = 8;
   localparam int DIV_IN_W = 32;
   localparam int RECIP_W = 33;
   localparam int RECIP_SHIFT = 51;
   localparam logic [RECIP_W-1:0] RECIP = 33'd5764607524;

   localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      43'sd450000000000, 43'sd265650511771, 43'sd140362434679, 43'sd71250163489,
      43'sd35763343750, 43'sd17899106082, 43'sd8951737102, 43'sd4476141709,
      43'sd2238105004, 43'sd1119056771, 43'sd559528919, 43'sd279764526,
      43'sd139882271, 43'sd69941137, 43'sd34970569, 43'sd17485284,
      43'sd8742642, 43'sd4371321, 43'sd2185661, 43'sd1092830,
      43'sd546415, 43'sd273208, 43'sd136604, 43'sd68302,
      43'sd34151, 43'sd17075, 43'sd8538, 43'sd4269,
      43'sd2134, 43'sd1067, 43'sd534, 43'sd267
   };

   typedef struct packed {
      logic bypass;
      logic bypass_max;
      logic degenerate;
      logic negate;
   } side_type;

   typedef struct packed {
      logic signed [CX_W-1:0] cx;
      logic signed [CX_W-1:0] cy;
      logic signed [ACC_W-1:0] acc;
   } cordic_type;

endpackage
`default_nettype wire

// ===== design/rrah_vec.sv =====
`default_nettype none
module rrah_vec #(
   parameter int QUAT_BITS = 16,
   parameter int MAG_W = 34
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire logic signed [QUAT_BITS-1:0] ref_w,
   input wire logic signed [QUAT_BITS-1:0] ref_x,
   input wire logic signed [QUAT_BITS-1:0] ref_y,
   input wire logic signed [QUAT_BITS-1:0] ref_z,
   input wire logic signed [QUAT_BITS-1:0] act_w,
   input wire logic signed [QUAT_BITS-1:0] act_x,
   input wire logic signed [QUAT_BITS-1:0] act_y,
   input wire logic signed [QUAT_BITS-1:0] act_z,
   output logic out_valid,
   input wire logic out_ready,
   output logic [MAG_W-1:0] out_mx,
   output logic [MAG_W-1:0] out_my,
   output rrah_pkg::side_type out_side
);
   import rrah_pkg::*;

   localparam int PROD_SHIFT = (QUAT_BITS > 31) ? 2 : 0;
   localparam int FULL_W = 2 * QUAT_BITS;
   localparam int PROD_W = FULL_W - PROD_SHIFT;
   localparam int NPROD = 12;

   logic signed [QUAT_BITS-1:0] op_a [NPROD];
   logic signed [QUAT_BITS-1:0] op_b [NPROD];
   logic signed [PROD_W-1:0] prod_in [NPROD];
   logic signed [PROD_W-1:0] prod_ff [NPROD];
   logic prod_valid_ff;
   logic prod_adv;

   logic signed [MAG_W-1:0] vx, vy, vz;
   logic [MAG_W-1:0] mx_in, my_in, mx_ff, my_ff;
   side_type side_in, side_ff;
   logic vec_valid_ff;
   logic vec_adv;

   always_comb begin
      op_a[0] = act_w;  op_b[0] = ref_x;
      op_a[1] = act_x;  op_b[1] = ref_w;
      op_a[2] = act_y;  op_b[2] = ref_z;
      op_a[3] = act_z;  op_b[3] = ref_y;
      op_a[4] = act_w;  op_b[4] = ref_y;
      op_a[5] = act_x;  op_b[5] = ref_z;
      op_a[6] = act_y;  op_b[6] = ref_w;
      op_a[7] = act_z;  op_b[7] = ref_x;
      op_a[8] = act_w;  op_b[8] = ref_z;
      op_a[9] = act_x;  op_b[9] = ref_y;
      op_a[10] = act_y; op_b[10] = ref_x;
      op_a[11] = act_z; op_b[11] = ref_w;
   end

   for (genvar g = 0; g < NPROD; g++) begin : g_prod
      logic signed [FULL_W-1:0] full;
      assign full = op_a[g] * op_b[g];
      // floor shift keeps the widest sums inside range
      assign prod_in[g] = PROD_W'(full >>> PROD_SHIFT);
   end

   assign prod_adv = !prod_valid_ff || vec_adv;
   assign in_ready = prod_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (prod_adv) begin
         prod_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_adv && in_valid) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      vx = MAG_W'(prod_ff[1]) + MAG_W'(prod_ff[3]) - MAG_W'(prod_ff[0]) - MAG_W'(prod_ff[2]);
      vy = MAG_W'(prod_ff[5]) + MAG_W'(prod_ff[6]) - MAG_W'(prod_ff[4]) - MAG_W'(prod_ff[7]);
      vz = MAG_W'(prod_ff[10]) + MAG_W'(prod_ff[11]) - MAG_W'(prod_ff[8]) - MAG_W'(prod_ff[9]);
      mx_in = vx[MAG_W-1] ? MAG_W'(-vx) : MAG_W'(vx);
      my_in = vy[MAG_W-1] ? MAG_W'(-vy) : MAG_W'(vy);
      side_in.degenerate = (mx_in == '0) && (my_in == '0) && (vz != '0);
      side_in.bypass = (mx_in == '0) || (my_in == '0);
      side_in.bypass_max = (my_in == '0) && !side_in.degenerate;
      // both nonzero on the cordic path, so equal signs mean same quadrant sense
      side_in.negate = (vx[MAG_W-1] == vy[MAG_W-1]);
   end

   assign vec_adv = !vec_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_valid_ff <= 1'b0;
      end else if (vec_adv) begin
         vec_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (vec_adv && prod_valid_ff) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = vec_valid_ff;
   assign out_mx = mx_ff;
   assign out_my = my_ff;
   assign out_side = side_ff;

endmodule
`default_nettype wire

// ===== design/rrah_norm_cell.sv =====
`default_nettype none
module rrah_norm_cell #(
   parameter int W = 58,
   parameter int SHIFT = 1
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire logic [W-1:0] in_x,
   input wire logic [W-1:0] in_y,
   input wire rrah_pkg::side_type in_side,
   output logic out_valid,
   input wire logic out_ready,
   output logic [W-1:0] out_x,
   output logic [W-1:0] out_y,
   output rrah_pkg::side_type out_side
);
   import rrah_pkg::*;

   logic [W-1:0] m;
   logic go_right, go_left;
   logic [W-1:0] x_in, y_in, x_ff, y_ff;
   side_type side_ff;
   logic valid_ff;
   logic adv;

   always_comb begin
      m = (in_x > in_y) ? in_x : in_y;
      go_right = (m >> (NORM_TOP - 1 + SHIFT)) != '0;
      go_left = (m >> (NORM_TOP - SHIFT)) == '0;
      if (go_right) begin
         x_in = in_x >> SHIFT;
         y_in = in_y >> SHIFT;
      end else if (go_left) begin
         x_in = in_x << SHIFT;
         y_in = in_y << SHIFT;
      end else begin
         x_in = in_x;
         y_in = in_y;
      end
   end

   assign adv = !valid_ff || out_ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         x_ff <= x_in;
         y_ff <= y_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_side = side_ff;

endmodule
`default_nettype wire

// ===== design/rrah_cordic_cell.sv =====
`default_nettype none
module rrah_cordic_cell #(
   parameter int STEP = 0
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire rrah_pkg::cordic_type in_data,
   input wire rrah_pkg::side_type in_side,
   output logic out_valid,
   input wire logic out_ready,
   output rrah_pkg::cordic_type out_data,
   output rrah_pkg::side_type out_side
);
   import rrah_pkg::*;

   logic signed [CX_W-1:0] cx, cy, sx, sy;
   logic signed [ACC_W-1:0] acc;
   cordic_type data_in, data_ff;
   side_type side_ff;
   logic valid_ff;
   logic adv;

   always_comb begin
      cx = in_data.cx;
      cy = in_data.cy;
      acc = in_data.acc;
      sx = cx >>> STEP;
      sy = cy >>> STEP;
      if (!cy[CX_W-1] && (cy != '0)) begin
         data_in.cx = cx + sy;
         data_in.cy = cy - sx;
         data_in.acc = acc + ATAN_TAB[STEP];
      end else begin
         data_in.cx = cx - sy;
         data_in.cy = cy + sx;
         data_in.acc = acc - ATAN_TAB[STEP];
      end
   end

   assign adv = !valid_ff || out_ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         data_ff <= data_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
   assign out_side = side_ff;

endmodule
`default_nettype wire

// ===== design/rrah_div_cell.sv =====
`default_nettype none
module rrah_div_cell (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire logic [rrah_pkg::REM_W-1:0] in_rem,
   input wire rrah_pkg::side_type in_side,
   output logic out_valid,
   input wire logic out_ready,
   output logic [rrah_pkg::QUOT_W-1:0] out_quot,
   output rrah_pkg::side_type out_side
);
   import rrah_pkg::*;

   localparam int PROD_W = DIV_IN_W + RECIP_W;

   logic too_big;
   logic [DIV_IN_W-1:0] scaled;
   logic [PROD_W-1:0] prod;
   logic [QUOT_W-1:0] quot_in, quot_ff;
   side_type side_ff;
   logic valid_ff;
   logic adv;

   // divide by one hundredth of a degree: drop 2^8, then multiply by 1/5^8
   always_comb begin
      too_big = in_rem[REM_W-1:PRE_SHIFT+DIV_IN_W] != '0;
      scaled = in_rem[PRE_SHIFT +: DIV_IN_W];
      prod = PROD_W'(scaled) * PROD_W'(RECIP);
      quot_in = too_big ? '1 : QUOT_W'(prod >> RECIP_SHIFT);
   end

   assign adv = !valid_ff || out_ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         quot_ff <= quot_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_quot = quot_ff;
   assign out_side = side_ff;

endmodule
`default_nettype wire

// ===== design/relative_rotation_axis_heading.sv =====
// channel    | valid / ready          | payload
// request    | req_valid / req_ready  | req_ref_w..z, req_act_w..z (QUAT_BITS, signed)
// response   | rsp_valid / rsp_ready  | rsp_heading_angle (15, signed), rsp_degenerate
//
// one request per cycle unless a stall holds the pipeline; from request to response it passes
// 2 product/sum stages, 6 normalize cells, 32 cordic cells, 1 divide cell, 1 output.
// the cordic chain sets the latency; every cell holds its own valid and takes a
// new request whenever its successor moves, so bubbles close up under stalls.
// synchronous reset clears all valid bits; no warm-up after reset.
`default_nettype none
module relative_rotation_axis_heading #(
   parameter int QUAT_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic signed [QUAT_BITS-1:0] req_ref_w,
   input wire logic signed [QUAT_BITS-1:0] req_ref_x,
   input wire logic signed [QUAT_BITS-1:0] req_ref_y,
   input wire logic signed [QUAT_BITS-1:0] req_ref_z,
   input wire logic signed [QUAT_BITS-1:0] req_act_w,
   input wire logic signed [QUAT_BITS-1:0] req_act_x,
   input wire logic signed [QUAT_BITS-1:0] req_act_y,
   input wire logic signed [QUAT_BITS-1:0] req_act_z,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic signed [rrah_pkg::ANGLE_W-1:0] rsp_heading_angle,
   output logic rsp_degenerate
);
   import rrah_pkg::*;

   localparam int PROD_SHIFT = (QUAT_BITS > 31) ? 2 : 0;
   localparam int MAG_W = 2 * QUAT_BITS - PROD_SHIFT + 2;
   localparam int NORM_W = (MAG_W > NORM_TOP) ? MAG_W : NORM_TOP;

   logic vec_valid;
   logic [MAG_W-1:0] vec_mx, vec_my;
   side_type vec_side;

   logic norm_valid [NORM_STEPS+1];
   logic norm_ready [NORM_STEPS+1];
   logic [NORM_W-1:0] norm_x [NORM_STEPS+1];
   logic [NORM_W-1:0] norm_y [NORM_STEPS+1];
   side_type norm_side [NORM_STEPS+1];

   logic cor_valid [CORDIC_STEPS+1];
   logic cor_ready [CORDIC_STEPS+1];
   cordic_type cor_data [CORDIC_STEPS+1];
   side_type cor_side [CORDIC_STEPS+1];

   logic [REM_W-1:0] div_rem;
   logic div_valid;
   logic div_ready;
   side_type div_side;

   logic [QUOT_W-1:0] quot;
   logic [ANGLE_W-1:0] mag;
   logic [ANGLE_W-1:0] angle_in, angle_ff;
   logic degenerate_ff;
   logic rsp_valid_ff;
   logic out_adv;
   cordic_type cor_last;

   rrah_vec #(
      .QUAT_BITS(QUAT_BITS),
      .MAG_W(MAG_W)
   ) u_vec (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid),
      .in_ready(req_ready),
      .ref_w(req_ref_w),
      .ref_x(req_ref_x),
      .ref_y(req_ref_y),
      .ref_z(req_ref_z),
      .act_w(req_act_w),
      .act_x(req_act_x),
      .act_y(req_act_y),
      .act_z(req_act_z),
      .out_valid(vec_valid),
      .out_ready(norm_ready[0]),
      .out_mx(vec_mx),
      .out_my(vec_my),
      .out_side(vec_side)
   );

   // angle is measured from the y axis: |vy| runs along x, |vx| along y
   assign norm_valid[0] = vec_valid;
   assign norm_x[0] = NORM_W'(vec_my);
   assign norm_y[0] = NORM_W'(vec_mx);
   assign norm_side[0] = vec_side;

   for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
      rrah_norm_cell #(
         .W(NORM_W),
         .SHIFT(1 << (NORM_STEPS - 1 - j))
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .in_valid(norm_valid[j]),
         .in_ready(norm_ready[j]),
         .in_x(norm_x[j]),
         .in_y(norm_y[j]),
         .in_side(norm_side[j]),
         .out_valid(norm_valid[j+1]),
         .out_ready(norm_ready[j+1]),
         .out_x(norm_x[j+1]),
         .out_y(norm_y[j+1]),
         .out_side(norm_side[j+1])
      );
   end

   // accumulator starts at half a hundredth so the divide rounds to nearest
   assign cor_valid[0] = norm_valid[NORM_STEPS];
   assign norm_ready[NORM_STEPS] = cor_ready[0];
   assign cor_data[0].cx = {{(CX_W-NORM_TOP){1'b0}}, norm_x[NORM_STEPS][NORM_TOP-1:0]};
   assign cor_data[0].cy = {{(CX_W-NORM_TOP){1'b0}}, norm_y[NORM_STEPS][NORM_TOP-1:0]};
   assign cor_data[0].acc = HALF_HUNDREDTH;
   assign cor_side[0] = norm_side[NORM_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      rrah_cordic_cell #(
         .STEP(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .in_valid(cor_valid[i]),
         .in_ready(cor_ready[i]),
         .in_data(cor_data[i]),
         .in_side(cor_side[i]),
         .out_valid(cor_valid[i+1]),
         .out_ready(cor_ready[i+1]),
         .out_data(cor_data[i+1]),
         .out_side(cor_side[i+1])
      );
   end

   // a negative angle rounds to zero, so it enters the divide as zero
   assign cor_last = cor_data[CORDIC_STEPS];
   assign div_rem = cor_last.acc[ACC_W-1] ? '0 : REM_W'(unsigned'(cor_last.acc));

   rrah_div_cell u_div (
      .clock(clock),
      .reset(reset),
      .in_valid(cor_valid[CORDIC_STEPS]),
      .in_ready(cor_ready[CORDIC_STEPS]),
      .in_rem(div_rem),
      .in_side(cor_side[CORDIC_STEPS]),
      .out_valid(div_valid),
      .out_ready(div_ready),
      .out_quot(quot),
      .out_side(div_side)
   );

   always_comb begin
      mag = (quot > QUOT_W'(ANGLE_LIMIT)) ? ANGLE_W'(ANGLE_LIMIT) : quot[ANGLE_W-1:0];
      if (div_side.bypass) begin
         angle_in = div_side.bypass_max ? ANGLE_W'(ANGLE_LIMIT) : '0;
      end else begin
         angle_in = div_side.negate ? ANGLE_W'(-mag) : mag;
      end
   end

   assign out_adv = !rsp_valid_ff || rsp_ready;
   assign div_ready = out_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && div_valid) begin
         angle_ff <= angle_in;
         degenerate_ff <= div_side.degenerate;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_heading_angle = signed'(angle_ff);
   assign rsp_degenerate = degenerate_ff;

endmodule
`default_nettype wire

// ===== design/rrah_checker.sv =====
`default_nettype none
module rrah_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic signed [rrah_pkg::ANGLE_W-1:0] rsp_heading_angle,
   input wire logic rsp_degenerate
);
   import rrah_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_heading_angle)
         && $stable(rsp_degenerate))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_heading_angle == '0)
      else $error("degenerate response with nonzero angle");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading_angle <= ANGLE_W'(ANGLE_LIMIT))
         && (rsp_heading_angle >= -ANGLE_W'(ANGLE_LIMIT)))
      else $error("angle outside the folded range");

endmodule

bind relative_rotation_axis_heading rrah_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_heading_angle(rsp_heading_angle),
   .rsp_degenerate(rsp_degenerate)
);
`default_nettype wire
